@@ sv/tgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types and constants of the track group rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

	localparam int MaxTracks = 64;
	localparam int IdxW      = $clog2(MaxTracks);
	localparam int CntW      = $clog2(MaxTracks + 1);
	localparam int NodeBits  = 32;
	localparam int OffW      = 16;
	localparam int BitCntW   = $clog2(OffW);

	typedef enum logic [2:0] {
		OP_APPEND     = 3'd0,
		OP_SET_NODE   = 3'd1,
		OP_MARK_START = 3'd2,
		OP_MARK_END   = 3'd3,
		OP_ROTATE     = 3'd4,
		OP_READ       = 3'd5,
		OP_COUNT      = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_MRK_RD,
		S_MRK_WR,
		S_CNT_RD,
		S_CNT_ACC,
		S_HD_RD,
		S_HD_CHK,
		S_GR_RD,
		S_GR_CHK,
		S_MOD,
		S_WB_RD,
		S_WB_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  track_pos;
		logic [31:0] node_id;
		logic [1:0]  direction;
		logic [7:0]  segment_id;
		logic [7:0]  segment_length;
		logic        start_flag;
		logic        end_flag;
		logic [15:0] rotate_offset;
		logic        reverse_rotate;
	} cmd_t;

	typedef struct packed {
		logic [31:0] out_node_id;
		logic [1:0]  out_direction;
		logic [7:0]  out_segment_id;
		logic [7:0]  out_segment_length;
		logic        out_start;
		logic        out_end;
		logic [6:0]  track_count;
		logic [6:0]  start_count;
		logic [6:0]  end_count;
		logic        error;
	} rsp_t;

	// Per-track attributes kept side by side in one memory word.
	typedef struct packed {
		logic [1:0] direction;
		logic [7:0] segment_id;
		logic [7:0] segment_length;
		logic       start_mark;
		logic       end_mark;
	} attr_t;

endpackage

`default_nettype wire

@@ sv/tgr_if.sv @@
// ----------------------------------------------------------------------------
// tgr_if
// Valid/ready channels for command beats and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgr_cmd_if;
	logic          valid;
	logic          ready;
	tgr_pkg::cmd_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tgr_rsp_if;
	logic          valid;
	logic          ready;
	tgr_pkg::rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/tgr_ram.sv @@
// ----------------------------------------------------------------------------
// tgr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/track_group_rotator.sv @@
// ----------------------------------------------------------------------------
// track_group_rotator
// Table of routing tracks with append, update, mark, count, read, clear and
// group-wise rotation of node ids, run by a small sequencer over RAMs.
// ----------------------------------------------------------------------------
//
//   Channel  Role  Beat contents
//   -------  ----  ---------------------------------------------------------
//   cmd      sink  one operation with its operands (tgr_pkg::cmd_t)
//   rsp      src   one result per operation (tgr_pkg::rsp_t)
//
// An append, set or clear and a failed read go from the execute state
// straight to done; a good read passes a read wait state first. Mark and
// count read each held track in turn, then mark or count it. Rotate walks
// over the heads, and for each group head found scans the tracks from the
// head up to and including the one that ends the scan, reduces the offset
// modulo the group size and writes back the group members; each track RAM
// has a single read port, which every step shares. The sequencer passes
// through its idle state after done before the next command is accepted.
// Reset clears the sequencer, the track count and the response valid; the
// RAMs are not cleared, since only entries below the track count are read.
// A new command is taken only while the sequencer idles; a finished result
// waits in the response register, and the sequencer holds in its done state
// only if an earlier response has still not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module track_group_rotator (
	input  logic      clk,
	input  logic      arst_n,
	tgr_cmd_if.sink   cmd,
	tgr_rsp_if.source rsp
);

	localparam int IdxW = tgr_pkg::IdxW;
	localparam int CntW = tgr_pkg::CntW;

	tgr_pkg::state_t state_q, state_d;

	// Latched command operands.
	tgr_pkg::op_t               op_q;
	logic [IdxW-1:0]            idx_q;
	logic [tgr_pkg::NodeBits-1:0] node_q;
	logic [1:0]                 dir_q;
	logic [7:0]                 seg_q;
	logic [7:0]                 len_q;
	logic                       sf_q;
	logic                       ef_q;
	logic [tgr_pkg::OffW-1:0]   off_q;
	logic                       rev_q;

	// Table and walk state.
	logic [CntW-1:0]            fill_q;
	logic [CntW-1:0]            i_q;
	logic [CntW-1:0]            head_q;
	logic [7:0]                 hseg_q;
	logic [CntW-1:0]            n_q;
	logic [CntW-1:0]            k_q;
	logic [tgr_pkg::OffW-1:0]   div_q;
	logic [CntW-1:0]            rem_q;
	logic [tgr_pkg::BitCntW-1:0] bc_q;
	logic [CntW-1:0]            sc_q;
	logic [CntW-1:0]            ec_q;
	logic                       err_q;
	logic [tgr_pkg::NodeBits-1:0] rd_node_q;
	tgr_pkg::attr_t             rd_attr_q;

	tgr_pkg::rsp_t              rsp_q;
	tgr_pkg::rsp_t              rsp_d;
	logic                       rsp_valid_q;

	// RAM ports.
	logic                         node_we, attr_we, gid_we, gpos_we;
	logic [IdxW-1:0]              node_waddr, attr_waddr, grp_waddr;
	logic [IdxW-1:0]              node_raddr, attr_raddr, gid_raddr, gpos_raddr;
	logic [tgr_pkg::NodeBits-1:0] node_wdata, node_rdata, gid_rdata;
	tgr_pkg::attr_t               attr_wdata, attr_rdata;
	logic [IdxW-1:0]              gpos_rdata;

	// Derived conditions.
	logic            hit_dir, grp_match, grp_break;
	logic            walk_last, head_last, wb_last, bc_last;
	logic            append_ok, index_ok;
	logic [CntW:0]   mod_trial, wb_sum, wb_src;
	logic            mod_ge;
	logic            rsp_free;

	assign hit_dir   = attr_rdata.direction == dir_q;
	assign grp_match = hit_dir && (attr_rdata.segment_id == hseg_q);
	assign grp_break = grp_match && attr_rdata.start_mark && (i_q != head_q);
	assign walk_last = (i_q + CntW'(1)) == fill_q;
	assign head_last = (head_q + CntW'(1)) == fill_q;
	assign wb_last   = (k_q + CntW'(1)) == n_q;
	assign bc_last   = bc_q == tgr_pkg::BitCntW'(tgr_pkg::OffW - 1);
	assign append_ok = fill_q != CntW'(tgr_pkg::MaxTracks);
	assign index_ok  = {1'b0, idx_q} < fill_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	// One restoring-division step per cycle reduces the offset modulo n.
	assign mod_trial = {rem_q, div_q[tgr_pkg::OffW-1]};
	assign mod_ge    = mod_trial >= {1'b0, n_q};

	// Source slot for the write-back; both sums stay below twice n.
	always_comb begin
		if (rev_q) begin
			wb_sum = {1'b0, k_q} + {1'b0, n_q} - {1'b0, rem_q};
		end else begin
			wb_sum = {1'b0, k_q} + {1'b0, rem_q};
		end
		if (wb_sum >= {1'b0, n_q}) begin
			wb_src = wb_sum - {1'b0, n_q};
		end else begin
			wb_src = wb_sum;
		end
	end

	// Response of the finished operation; track fields only for a good read.
	always_comb begin
		rsp_d = '0;
		if (op_q == tgr_pkg::OP_READ && !err_q) begin
			rsp_d.out_node_id        = rd_node_q;
			rsp_d.out_direction      = rd_attr_q.direction;
			rsp_d.out_segment_id     = rd_attr_q.segment_id;
			rsp_d.out_segment_length = rd_attr_q.segment_length;
			rsp_d.out_start          = rd_attr_q.start_mark;
			rsp_d.out_end            = rd_attr_q.end_mark;
		end
		if (op_q == tgr_pkg::OP_COUNT) begin
			rsp_d.start_count = sc_q;
			rsp_d.end_count   = ec_q;
		end
		rsp_d.track_count = fill_q;
		rsp_d.error       = err_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tgr_pkg::S_IDLE: begin
				if (cmd.valid) begin
					state_d = tgr_pkg::S_EXEC;
				end
			end
			tgr_pkg::S_EXEC: begin
				unique case (op_q) inside
					tgr_pkg::OP_MARK_START, tgr_pkg::OP_MARK_END: begin
						state_d = (fill_q == '0) ? tgr_pkg::S_DONE : tgr_pkg::S_MRK_RD;
					end
					tgr_pkg::OP_COUNT: begin
						state_d = (fill_q == '0) ? tgr_pkg::S_DONE : tgr_pkg::S_CNT_RD;
					end
					tgr_pkg::OP_ROTATE: begin
						state_d = (fill_q == '0 || off_q == '0) ? tgr_pkg::S_DONE
							: tgr_pkg::S_HD_RD;
					end
					tgr_pkg::OP_READ: begin
						state_d = index_ok ? tgr_pkg::S_RD_WAIT : tgr_pkg::S_DONE;
					end
					default: begin
						state_d = tgr_pkg::S_DONE;
					end
				endcase
			end
			tgr_pkg::S_RD_WAIT: state_d = tgr_pkg::S_DONE;
			tgr_pkg::S_MRK_RD:  state_d = tgr_pkg::S_MRK_WR;
			tgr_pkg::S_MRK_WR: begin
				state_d = walk_last ? tgr_pkg::S_DONE : tgr_pkg::S_MRK_RD;
			end
			tgr_pkg::S_CNT_RD:  state_d = tgr_pkg::S_CNT_ACC;
			tgr_pkg::S_CNT_ACC: begin
				state_d = walk_last ? tgr_pkg::S_DONE : tgr_pkg::S_CNT_RD;
			end
			tgr_pkg::S_HD_RD:   state_d = tgr_pkg::S_HD_CHK;
			tgr_pkg::S_HD_CHK: begin
				if (attr_rdata.start_mark && hit_dir) begin
					state_d = tgr_pkg::S_GR_RD;
				end else begin
					state_d = head_last ? tgr_pkg::S_DONE : tgr_pkg::S_HD_RD;
				end
			end
			tgr_pkg::S_GR_RD:   state_d = tgr_pkg::S_GR_CHK;
			tgr_pkg::S_GR_CHK: begin
				state_d = (grp_break || walk_last) ? tgr_pkg::S_MOD : tgr_pkg::S_GR_RD;
			end
			tgr_pkg::S_MOD: begin
				state_d = bc_last ? tgr_pkg::S_WB_RD : tgr_pkg::S_MOD;
			end
			tgr_pkg::S_WB_RD:   state_d = tgr_pkg::S_WB_WR;
			tgr_pkg::S_WB_WR: begin
				if (!wb_last) begin
					state_d = tgr_pkg::S_WB_RD;
				end else begin
					state_d = head_last ? tgr_pkg::S_DONE : tgr_pkg::S_HD_RD;
				end
			end
			tgr_pkg::S_DONE: begin
				state_d = rsp_free ? tgr_pkg::S_IDLE : tgr_pkg::S_DONE;
			end
			default: state_d = tgr_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and RAM controls.
	always_comb begin
		cmd.ready  = state_q == tgr_pkg::S_IDLE;
		node_we    = 1'b0;
		node_waddr = fill_q[IdxW-1:0];
		node_wdata = node_q;
		attr_we    = 1'b0;
		attr_waddr = fill_q[IdxW-1:0];
		attr_wdata = '{direction: dir_q, segment_id: seg_q, segment_length: len_q,
			start_mark: sf_q, end_mark: ef_q};
		gid_we     = 1'b0;
		gpos_we    = 1'b0;
		grp_waddr  = n_q[IdxW-1:0];
		node_raddr = i_q[IdxW-1:0];
		attr_raddr = i_q[IdxW-1:0];
		gid_raddr  = wb_src[IdxW-1:0];
		gpos_raddr = k_q[IdxW-1:0];
		unique case (state_q)
			tgr_pkg::S_EXEC: begin
				node_raddr = idx_q;
				attr_raddr = idx_q;
				if (op_q == tgr_pkg::OP_APPEND && append_ok) begin
					node_we = 1'b1;
					attr_we = 1'b1;
				end
				if (op_q == tgr_pkg::OP_SET_NODE && index_ok) begin
					node_we    = 1'b1;
					node_waddr = idx_q;
				end
			end
			tgr_pkg::S_MRK_WR: begin
				attr_waddr = i_q[IdxW-1:0];
				attr_wdata = attr_rdata;
				if (op_q == tgr_pkg::OP_MARK_START) begin
					attr_wdata.start_mark = 1'b1;
				end else begin
					attr_wdata.end_mark = 1'b1;
				end
				attr_we = hit_dir;
			end
			tgr_pkg::S_HD_RD: begin
				attr_raddr = head_q[IdxW-1:0];
			end
			tgr_pkg::S_GR_CHK: begin
				gid_we  = grp_match && !grp_break;
				gpos_we = grp_match && !grp_break;
			end
			tgr_pkg::S_WB_WR: begin
				node_we    = 1'b1;
				node_waddr = gpos_rdata;
				node_wdata = gid_rdata;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tgr_pkg::S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tgr_pkg::S_EXEC) begin
				if (op_q == tgr_pkg::OP_APPEND && append_ok) begin
					fill_q <= fill_q + CntW'(1);
				end else if (op_q == tgr_pkg::OP_CLEAR) begin
					fill_q <= '0;
				end
			end
			if (state_q == tgr_pkg::S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			tgr_pkg::S_IDLE: begin
				if (cmd.valid) begin
					op_q   <= tgr_pkg::op_t'(cmd.payload.op);
					idx_q  <= cmd.payload.track_pos;
					node_q <= cmd.payload.node_id;
					dir_q  <= cmd.payload.direction;
					seg_q  <= cmd.payload.segment_id;
					len_q  <= cmd.payload.segment_length;
					sf_q   <= cmd.payload.start_flag;
					ef_q   <= cmd.payload.end_flag;
					off_q  <= cmd.payload.rotate_offset;
					rev_q  <= cmd.payload.reverse_rotate;
				end
			end
			tgr_pkg::S_EXEC: begin
				err_q  <= (op_q == tgr_pkg::OP_APPEND && !append_ok)
					|| ((op_q == tgr_pkg::OP_SET_NODE || op_q == tgr_pkg::OP_READ)
					&& !index_ok);
				i_q    <= '0;
				head_q <= '0;
				sc_q   <= '0;
				ec_q   <= '0;
			end
			tgr_pkg::S_RD_WAIT: begin
				rd_node_q <= node_rdata;
				rd_attr_q <= attr_rdata;
			end
			tgr_pkg::S_MRK_WR: begin
				i_q <= i_q + CntW'(1);
			end
			tgr_pkg::S_CNT_ACC: begin
				if (hit_dir && attr_rdata.start_mark) begin
					sc_q <= sc_q + CntW'(1);
				end
				if (hit_dir && attr_rdata.end_mark) begin
					ec_q <= ec_q + CntW'(1);
				end
				i_q <= i_q + CntW'(1);
			end
			tgr_pkg::S_HD_CHK: begin
				hseg_q <= attr_rdata.segment_id;
				i_q    <= head_q;
				n_q    <= '0;
				// A head keeps its place until its group is written back.
				if (!(attr_rdata.start_mark && hit_dir)) begin
					head_q <= head_q + CntW'(1);
				end
			end
			tgr_pkg::S_GR_CHK: begin
				if (grp_match && !grp_break) begin
					n_q <= n_q + CntW'(1);
				end
				i_q   <= i_q + CntW'(1);
				div_q <= off_q;
				rem_q <= '0;
				bc_q  <= '0;
			end
			tgr_pkg::S_MOD: begin
				rem_q <= mod_ge ? CntW'(mod_trial - {1'b0, n_q}) : CntW'(mod_trial);
				div_q <= div_q << 1;
				bc_q  <= bc_q + tgr_pkg::BitCntW'(1);
				k_q   <= '0;
			end
			tgr_pkg::S_WB_WR: begin
				k_q <= k_q + CntW'(1);
				if (wb_last) begin
					head_q <= head_q + CntW'(1);
				end
			end
			tgr_pkg::S_DONE: begin
				if (rsp_free) begin
					rsp_q <= rsp_d;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	tgr_ram #(.Width(tgr_pkg::NodeBits), .Depth(tgr_pkg::MaxTracks)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	tgr_ram #(.Width($bits(tgr_pkg::attr_t)), .Depth(tgr_pkg::MaxTracks)) u_attr_ram (
		.clk(clk), .we(attr_we), .waddr(attr_waddr), .wdata(attr_wdata),
		.raddr(attr_raddr), .rdata(attr_rdata)
	);

	// Group scratch buffers: gathered node ids and their table positions.
	tgr_ram #(.Width(tgr_pkg::NodeBits), .Depth(tgr_pkg::MaxTracks)) u_gid_ram (
		.clk(clk), .we(gid_we), .waddr(grp_waddr), .wdata(node_rdata),
		.raddr(gid_raddr), .rdata(gid_rdata)
	);

	tgr_ram #(.Width(IdxW), .Depth(tgr_pkg::MaxTracks)) u_gpos_ram (
		.clk(clk), .we(gpos_we), .waddr(grp_waddr), .wdata(i_q[IdxW-1:0]),
		.raddr(gpos_raddr), .rdata(gpos_rdata)
	);

`ifndef SYNTH
	// The reduced offset always lies below the group size before write-back.
	a_rem_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tgr_pkg::S_WB_RD |-> rem_q < n_q)
		else $error("reduced offset not below group size");

	// A group always holds at least its head once the scan is over.
	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tgr_pkg::S_MOD |-> n_q != '0)
		else $error("empty group reached offset reduction");

	// The track count moves only by one append or back to zero.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> (fill_q == $past(fill_q) + CntW'(1)) || (fill_q == '0))
		else $error("track count jumped");

	// The track count never passes the table size.
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> rsp_q.track_count <= CntW'(tgr_pkg::MaxTracks))
		else $error("track count beyond table size");
`endif

endmodule

`default_nettype wire

@@ bench/track_group_rotator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// track_group_rotator_checker
// Watches the command and response channels, keeps its own copy of the track
// table, works out the response of every accepted command and compares the
// responses of the block with it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module track_group_rotator_checker (
	input  logic clk,
	input  logic arst_n,
	tgr_cmd_if   cmd,
	tgr_rsp_if   rsp,
	output int   failures,
	output int   outstanding
);

	logic [31:0] node_tab [tgr_pkg::MaxTracks];
	logic [1:0]  dir_tab  [tgr_pkg::MaxTracks];
	logic [7:0]  seg_tab  [tgr_pkg::MaxTracks];
	logic [7:0]  len_tab  [tgr_pkg::MaxTracks];
	logic        start_tab[tgr_pkg::MaxTracks];
	logic        end_tab  [tgr_pkg::MaxTracks];
	int          tracks_held;

	tgr_pkg::rsp_t expected_rsp[$];

	// Rotates the node ids of every group headed by a start track of dir.
	function automatic void rotate_node_groups(logic [1:0] dir, int offset, bit reverse);
		logic [31:0] ids[tgr_pkg::MaxTracks];
		int          pos[tgr_pkg::MaxTracks];
		int          n;
		int          off;
		if (offset == 0)
			return;
		for (int head = 0; head < tracks_held; head++) begin
			if (!start_tab[head] || dir_tab[head] != dir)
				continue;
			n = 0;
			for (int i = head; i < tracks_held; i++) begin
				if (dir_tab[i] != dir_tab[head] || seg_tab[i] != seg_tab[head])
					continue;
				if (start_tab[i] && i != head)
					break;
				pos[n] = i;
				ids[n] = node_tab[i];
				n++;
			end
			off = offset % n;
			for (int k = 0; k < n; k++)
				node_tab[pos[k]] = reverse ? ids[(k + n - off) % n] : ids[(k + off) % n];
		end
	endfunction

	function automatic tgr_pkg::rsp_t apply_command(tgr_pkg::cmd_t c);
		tgr_pkg::rsp_t r;
		r = '0;
		case (tgr_pkg::op_t'(c.op))
			tgr_pkg::OP_APPEND: begin
				if (tracks_held >= tgr_pkg::MaxTracks)
					r.error = 1'b1;
				else begin
					node_tab[tracks_held]  = c.node_id;
					dir_tab[tracks_held]   = c.direction;
					seg_tab[tracks_held]   = c.segment_id;
					len_tab[tracks_held]   = c.segment_length;
					start_tab[tracks_held] = c.start_flag;
					end_tab[tracks_held]   = c.end_flag;
					tracks_held++;
				end
			end
			tgr_pkg::OP_SET_NODE: begin
				if (int'(c.track_pos) >= tracks_held)
					r.error = 1'b1;
				else
					node_tab[c.track_pos] = c.node_id;
			end
			tgr_pkg::OP_MARK_START, tgr_pkg::OP_MARK_END: begin
				for (int i = 0; i < tracks_held; i++)
					if (dir_tab[i] == c.direction) begin
						if (tgr_pkg::op_t'(c.op) == tgr_pkg::OP_MARK_START)
							start_tab[i] = 1'b1;
						else
							end_tab[i] = 1'b1;
					end
			end
			tgr_pkg::OP_ROTATE:
				rotate_node_groups(c.direction, int'(c.rotate_offset), c.reverse_rotate);
			tgr_pkg::OP_READ: begin
				if (int'(c.track_pos) >= tracks_held)
					r.error = 1'b1;
				else begin
					r.out_node_id        = node_tab[c.track_pos];
					r.out_direction      = dir_tab[c.track_pos];
					r.out_segment_id     = seg_tab[c.track_pos];
					r.out_segment_length = len_tab[c.track_pos];
					r.out_start          = start_tab[c.track_pos];
					r.out_end            = end_tab[c.track_pos];
				end
			end
			tgr_pkg::OP_COUNT: begin
				for (int i = 0; i < tracks_held; i++)
					if (dir_tab[i] == c.direction) begin
						r.start_count += 7'(start_tab[i]);
						r.end_count   += 7'(end_tab[i]);
					end
			end
			default: tracks_held = 0;
		endcase
		r.track_count = tracks_held[6:0];
		return r;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
		failures++;
	endtask

	task automatic compare_response(tgr_pkg::rsp_t got, tgr_pkg::rsp_t want);
		if (got.out_node_id !== want.out_node_id)
			report("out_node_id", got.out_node_id, want.out_node_id);
		if (got.out_direction !== want.out_direction)
			report("out_direction", 32'(got.out_direction), 32'(want.out_direction));
		if (got.out_segment_id !== want.out_segment_id)
			report("out_segment_id", 32'(got.out_segment_id), 32'(want.out_segment_id));
		if (got.out_segment_length !== want.out_segment_length)
			report("out_segment_length", 32'(got.out_segment_length),
				32'(want.out_segment_length));
		if (got.out_start !== want.out_start)
			report("out_start", 32'(got.out_start), 32'(want.out_start));
		if (got.out_end !== want.out_end)
			report("out_end", 32'(got.out_end), 32'(want.out_end));
		if (got.track_count !== want.track_count)
			report("track_count", 32'(got.track_count), 32'(want.track_count));
		if (got.start_count !== want.start_count)
			report("start_count", 32'(got.start_count), 32'(want.start_count));
		if (got.end_count !== want.end_count)
			report("end_count", 32'(got.end_count), 32'(want.end_count));
		if (got.error !== want.error)
			report("error", 32'(got.error), 32'(want.error));
	endtask

	initial begin
		failures    = 0;
		outstanding = 0;
		tracks_held = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (expected_rsp.size() == 0)
					report("response without command", 32'd1, 32'd0);
				else
					compare_response(rsp.payload, expected_rsp.pop_front());
			end
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
				expected_rsp.insert(expected_rsp.size(), apply_command(cmd.payload));
			outstanding = expected_rsp.size();
		end
	end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the track group rotator and takes its responses with
// random gaps and stalls; a checker beside the block predicts every response.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	logic clk;
	logic arst_n;
	int   failures;
	int   outstanding;

	tgr_cmd_if cmd();
	tgr_rsp_if rsp();

	track_group_rotator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.rsp    (rsp.source)
	);

	track_group_rotator_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rsp         (rsp),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Idling profile: 0 means the sender idles often and the receiver more,
	// 1 swaps the two, 2 runs both sides flat out.
	int beats_sent;
	int idle_phase;
	bit long_hold_done;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// The whole run should end far sooner; a hung handshake ends it here.
	initial begin
		#100_000_000;
		$display("** track_group_rotator: FAILED **");
		$finish;
	end

	// Receiver side. Ready changes only at the falling edge. Once, early in
	// the run, it is held low for a long stretch while commands keep coming,
	// so that the response register fills and the block stops taking input.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_hold_done && beats_sent >= 40) begin
				long_hold_done = 1'b1;
				rsp.ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			case (idle_phase)
				0:       rsp.ready <= ($urandom_range(0, 99) >= 75);
				1:       rsp.ready <= ($urandom_range(0, 99) >= 38);
				default: rsp.ready <= 1'b1;
			endcase
		end
	end

	// A command with every field random; callers then fix the fields that
	// matter, so that unused fields still carry both values on every bit.
	function automatic tgr_pkg::cmd_t noise_cmd();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return tgr_pkg::cmd_t'(raw[$bits(tgr_pkg::cmd_t)-1:0]);
	endfunction

	// Sends one command beat. Valid is dropped only when a gap is taken, so
	// back-to-back beats keep valid high without a second assignment.
	task automatic send(tgr_pkg::cmd_t c);
		int gap_pct;
		gap_pct = (idle_phase == 0) ? 38 : (idle_phase == 1) ? 75 : 0;
		if ($urandom_range(0, 99) < gap_pct) begin
			cmd.valid <= 1'b0;
			cmd.payload <= noise_cmd();
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < gap_pct);
		end
		cmd.valid   <= 1'b1;
		cmd.payload <= c;
		do
			@(posedge clk);
		while (cmd.ready !== 1'b1);
		beats_sent++;
		@(negedge clk);
	endtask

	function automatic tgr_pkg::cmd_t make_cmd(tgr_pkg::op_t op, int idx = 0,
			logic [31:0] node = 0, logic [1:0] dir = 0, logic [7:0] seg = 0,
			logic [7:0] len = 0, bit sf = 0, bit ef = 0, int offset = 0, bit rev = 0);
		tgr_pkg::cmd_t c;
		c                = noise_cmd();
		c.op             = op;
		c.track_pos      = 6'(idx);
		c.node_id        = node;
		c.direction      = dir;
		c.segment_id     = seg;
		c.segment_length = len;
		c.start_flag     = sf;
		c.end_flag       = ef;
		c.rotate_offset  = 16'(offset);
		c.reverse_rotate = rev;
		return c;
	endfunction

	// Random operation on a table that holds about held tracks. Indices fall
	// mostly inside the table, with some just past its end or anywhere.
	function automatic tgr_pkg::cmd_t table_op(int held);
		tgr_pkg::cmd_t c;
		int            pick;
		c    = noise_cmd();
		pick = $urandom_range(0, 99);
		if (pick < 12)
			c.op = tgr_pkg::OP_SET_NODE;
		else if (pick < 24)
			c.op = tgr_pkg::OP_MARK_START;
		else if (pick < 32)
			c.op = tgr_pkg::OP_MARK_END;
		else if (pick < 60)
			c.op = tgr_pkg::OP_ROTATE;
		else if (pick < 80)
			c.op = tgr_pkg::OP_READ;
		else if (pick < 92)
			c.op = tgr_pkg::OP_COUNT;
		else
			c.op = tgr_pkg::OP_APPEND;
		if ($urandom_range(0, 9) < 8)
			c.track_pos = 6'($urandom_range(0, held + 1));
		case ($urandom_range(0, 3))
			0:       c.rotate_offset = '0;
			1, 2:    c.rotate_offset = 16'($urandom_range(1, 9));
			default: ;
		endcase
		c.segment_id = 8'($urandom_range(0, 2));
		return c;
	endfunction

	initial begin
		tgr_pkg::cmd_t c;
		int            held;
		int            burst;

		arst_n          = 1'b0;
		cmd.valid       = 1'b0;
		cmd.payload     = '0;
		beats_sent      = 0;
		idle_phase      = 0;
		long_hold_done  = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: operations on an empty table, a small mixed table,
		// the zero offset, an offset far beyond the group size, a direction
		// that matches nothing, reads past the end, and clear.
		send(make_cmd(tgr_pkg::OP_READ, 0));
		send(make_cmd(tgr_pkg::OP_SET_NODE, 0, 32'h1234_5678));
		send(make_cmd(tgr_pkg::OP_COUNT, 0, 0, 2'd0));
		send(make_cmd(tgr_pkg::OP_ROTATE, 0, 0, 2'd0, 0, 0, 0, 0, 3));
		send(make_cmd(tgr_pkg::OP_APPEND, 0, 32'hFFFF_FFFF, 2'd0, 8'd5, 8'd255, 1, 0));
		send(make_cmd(tgr_pkg::OP_APPEND, 0, 32'h0000_0011, 2'd1, 8'd5, 8'd0, 0, 1));
		send(make_cmd(tgr_pkg::OP_APPEND, 0, 32'h0000_0022, 2'd0, 8'd5, 8'd7, 0, 0));
		send(make_cmd(tgr_pkg::OP_APPEND, 0, 32'h0000_0000, 2'd0, 8'd5, 8'd9, 0, 1));
		send(make_cmd(tgr_pkg::OP_APPEND, 0, 32'h8000_0000, 2'd3, 8'd255, 8'd1, 1, 1));
		send(make_cmd(tgr_pkg::OP_MARK_END, 0, 0, 2'd2));
		send(make_cmd(tgr_pkg::OP_MARK_END, 0, 0, 2'd1));
		send(make_cmd(tgr_pkg::OP_ROTATE, 0, 0, 2'd0, 0, 0, 0, 0, 0));
		send(make_cmd(tgr_pkg::OP_ROTATE, 0, 0, 2'd0, 0, 0, 0, 0, 1, 0));
		send(make_cmd(tgr_pkg::OP_ROTATE, 0, 0, 2'd0, 0, 0, 0, 0, 65535, 1));
		send(make_cmd(tgr_pkg::OP_ROTATE, 0, 0, 2'd2, 0, 0, 0, 0, 1, 1));
		send(make_cmd(tgr_pkg::OP_MARK_START, 0, 0, 2'd0));
		send(make_cmd(tgr_pkg::OP_ROTATE, 0, 0, 2'd0, 0, 0, 0, 0, 5, 1));
		send(make_cmd(tgr_pkg::OP_COUNT, 0, 0, 2'd0));
		send(make_cmd(tgr_pkg::OP_COUNT, 0, 0, 2'd1));
		for (int i = 0; i < 5; i++)
			send(make_cmd(tgr_pkg::OP_READ, i));
		send(make_cmd(tgr_pkg::OP_READ, 63));
		send(make_cmd(tgr_pkg::OP_SET_NODE, 4, 32'hA5A5_5A5A));
		send(make_cmd(tgr_pkg::OP_CLEAR));
		send(make_cmd(tgr_pkg::OP_READ, 0));

		// Random part: each run starts from a cleared table, fills it with
		// tracks whose directions and segment ids collide often, then works
		// on it. About one run in ten fills the table past its capacity.
		while (beats_sent < 430) begin
			idle_phase = (beats_sent < 170) ? 0 : (beats_sent < 320) ? 1 : 2;
			c    = noise_cmd();
			c.op = tgr_pkg::OP_CLEAR;
			send(c);
			held = ($urandom_range(0, 9) == 0) ? 66 : $urandom_range(1, 12);
			for (int i = 0; i < held; i++) begin
				c                = noise_cmd();
				c.op             = tgr_pkg::OP_APPEND;
				c.segment_id     = ($urandom_range(0, 7) == 0) ? c.segment_id :
					8'($urandom_range(0, 2));
				c.start_flag     = ($urandom_range(0, 3) == 0);
				send(c);
			end
			if (held > tgr_pkg::MaxTracks)
				held = tgr_pkg::MaxTracks;
			burst = $urandom_range(4, 14);
			for (int i = 0; i < burst; i++) begin
				if ($urandom_range(0, 19) == 0)
					send(noise_cmd());
				else
					send(table_op(held));
			end
		end

		cmd.valid <= 1'b0;
		idle_phase = 2;
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("** track_group_rotator: PASSED **");
		else
			$display("** track_group_rotator: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
